@@ hdl/lttbl_pkg.sv @@
// Package with the types and constants of the linear translation table.
`timescale 1ns / 1ps
package lttbl_pkg;

  localparam logic [1:0] ACT_MAP       = 2'd0;
  localparam logic [1:0] ACT_INSERT    = 2'd1;
  localparam logic [1:0] ACT_UNMAP     = 2'd2;
  localparam logic [1:0] ACT_TRANSLATE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  // Largest page code that map region picks; the stored code field is 3 bits wide.
  localparam int unsigned MAX_SIZE_CODE = 6;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] virt_page;
    logic [23:0] phys_page;
    logic [19:0] page_count;
    logic [2:0]  size_code;
    logic [2:0]  permissions;
    logic [3:0]  cache_mode;
    logic [2:0]  bus_attributes;
    logic [31:0] virtual_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [35:0] phys_address;
    logic [9:0]  pages_inserted;
    logic [8:0]  entry_index;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  perms;
    logic [19:0] vpn;
    logic [23:0] ppn;
    logic [2:0]  code;
    logic [3:0]  cache;
    logic [2:0]  bus;
  } entry_t;

  typedef struct packed {
    logic        is_free;
    logic        is_match;
    logic [35:0] paddr;
  } slot_eval_t;

endpackage

@@ hdl/lttbl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lttbl_ram #(
  parameter int unsigned WIDTH = 58,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lttbl_slot_unit.sv @@
// Shared slot evaluator: free test, masked page match and address formation.
`timescale 1ns / 1ps
module lttbl_slot_unit (
  input  lttbl_pkg::entry_t     entry_i,
  input  logic [19:0]           key_vpn_i,
  input  logic [31:0]           vaddr_i,
  output lttbl_pkg::slot_eval_t eval_o
);

  logic [4:0]  shamt;
  logic [4:0]  bits;
  logic [35:0] low;
  logic [19:0] diff;

  always_comb begin
    shamt = {1'b0, entry_i.code, 1'b0};
    bits  = 5'(lttbl_pkg::PAGE_SHIFT) + shamt;
    low   = (36'd1 << bits) - 36'd1;
    diff  = (key_vpn_i ^ entry_i.vpn) >> shamt;
    eval_o.is_free  = (entry_i.perms == 4'd0);
    eval_o.is_match = (entry_i.perms != 4'd0) && (diff == 20'd0);
    eval_o.paddr    = ({entry_i.ppn, 12'd0} & ~low) | ({4'd0, vaddr_i} & low);
  end

endmodule

@@ hdl/linear_translation_table_top.sv @@
// Top level of the linear translation table: sequencer, slot store and evaluator.
// Insert, unmap and translate scan the slots in order, reading and then evaluating each;
// map region picks a page code, scans, writes and advances for each page.
// Throughput: one command at a time; busy_o stays high until the result beat.
// The result beat is shown for one cycle with done_o; the receiver cannot stall.
// Reset clears the fill count, so the store reads empty at once with no clearing pass.
`timescale 1ns / 1ps
module linear_translation_table_top #(
  parameter int unsigned TABLE_DEPTH   = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  lttbl_pkg::req_t   req_i,
  output logic              done_o,
  output lttbl_pkg::rsp_t   rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CODE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_ADV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  lttbl_pkg::req_t req_q, req_d;
  logic [19:0] vp_q, vp_d;
  logic [23:0] pp_q, pp_d;
  logic [19:0] cnt_q, cnt_d;
  logic [2:0]  code_q, code_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] fill_q, fill_d;
  lttbl_pkg::rsp_t rsp_q, rsp_d;

  // Store and the shared evaluator.
  logic we;
  logic [AW-1:0] waddr;
  lttbl_pkg::entry_t wentry, rentry;
  logic [$bits(lttbl_pkg::entry_t)-1:0] rdata;
  logic [19:0] key_vpn;
  lttbl_pkg::slot_eval_t eval;

  lttbl_ram #(
    .WIDTH ($bits(lttbl_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rentry = lttbl_pkg::entry_t'(rdata);
  assign key_vpn = (req_q.action == lttbl_pkg::ACT_TRANSLATE)
                 ? req_q.virtual_address[31:12] : req_q.virt_page;

  lttbl_slot_unit u_slot (
    .entry_i   (rentry),
    .key_vpn_i (key_vpn),
    .vaddr_i   (req_q.virtual_address),
    .eval_o    (eval)
  );

  // Write-mode commands look for a free slot; the others look for a match.
  logic free_mode;
  assign free_mode = (req_q.action == lttbl_pkg::ACT_MAP) ||
                     (req_q.action == lttbl_pkg::ACT_INSERT);

  // Largest page that both alignments and the remaining length allow. The tests
  // are monotone in k, so the count of passing sizes is the chosen code.
  logic [23:0] align_w;
  logic [2:0]  code_calc;
  always_comb begin
    align_w = {4'd0, vp_q} | pp_q;
    code_calc = 3'd0;
    for (int k = 1; k <= int'(lttbl_pkg::MAX_SIZE_CODE); k++) begin
      if (((align_w & ((24'd1 << (2 * k)) - 24'd1)) == 24'd0) &&
          ({1'b0, cnt_q} >= (21'd1 << (2 * k)))) begin
        code_calc = code_calc + 3'd1;
      end
    end
  end

  logic [19:0] step;
  assign step = 20'd1 << {code_q, 1'b0};

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    vp_d    = vp_q;
    pp_d    = pp_q;
    cnt_d   = cnt_q;
    code_d  = code_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wentry  = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          vp_d  = req_i.virt_page;
          pp_d  = req_i.phys_page;
          cnt_d = req_i.page_count;
          idx_d = '0;
          rsp_d = '0;
          if (req_i.action == lttbl_pkg::ACT_MAP) begin
            state_d = (req_i.page_count == 20'd0) ? S_DONE : S_CODE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_CODE: begin
        code_d  = code_calc;
        state_d = S_RD;
      end
      S_RD: begin
        if (free_mode) begin
          if (idx_q == CW'(TABLE_DEPTH)) begin
            // No free slot left: the insert fails, map skips this page.
            rsp_d.status = lttbl_pkg::ST_FULL;
            state_d = (req_q.action == lttbl_pkg::ACT_MAP) ? S_ADV : S_DONE;
          end else if (idx_q >= fill_q) begin
            state_d = S_WR;
          end else begin
            state_d = S_EV;
          end
        end else begin
          if (idx_q >= fill_q) begin
            // The first never-written slot ends the lookup.
            rsp_d.status = lttbl_pkg::ST_NO_MATCH;
            state_d = S_DONE;
          end else begin
            state_d = S_EV;
          end
        end
      end
      S_EV: begin
        if (free_mode) begin
          if (eval.is_free) begin
            state_d = S_WR;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RD;
          end
        end else if (eval.is_match) begin
          rsp_d.entry_index = 9'(idx_q[AW-1:0]);
          if (req_q.action == lttbl_pkg::ACT_UNMAP) begin
            we     = 1'b1;
            wentry = '0;
          end else begin
            rsp_d.phys_address = eval.paddr;
          end
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_RD;
        end
      end
      S_WR: begin
        we = 1'b1;
        wentry.perms = {req_q.permissions, 1'b0};
        wentry.vpn   = vp_q;
        wentry.ppn   = pp_q;
        wentry.cache = req_q.cache_mode;
        wentry.bus   = req_q.bus_attributes;
        rsp_d.entry_index = 9'(idx_q[AW-1:0]);
        if (idx_q == fill_q) begin
          fill_d = fill_q + CW'(1);
        end
        if (req_q.action == lttbl_pkg::ACT_MAP) begin
          wentry.code = code_q;
          if (rsp_q.pages_inserted != lttbl_pkg::COUNT_MAX) begin
            rsp_d.pages_inserted = rsp_q.pages_inserted + 10'd1;
          end
          state_d = S_ADV;
        end else begin
          wentry.code = req_q.size_code;
          rsp_d.pages_inserted = 10'd1;
          state_d = S_DONE;
        end
      end
      S_ADV: begin
        // The scan position carries over to the next page of the region.
        vp_d  = vp_q + step;
        pp_d  = pp_q + {4'd0, step};
        cnt_d = cnt_q - step;
        state_d = (cnt_q == step) ? S_DONE : S_CODE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    vp_q   <= vp_d;
    pp_q   <= pp_d;
    cnt_q  <= cnt_d;
    code_q <= code_d;
    idx_q  <= idx_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = rsp_q;

endmodule
